[src/rwl_pkg.sv]
`timescale 1ns / 1ps

package rwl_pkg;

  localparam int SampleW = 26;
  localparam int ScoreW = 34;
  localparam int ItemsW = 11;

  localparam int MaxItemsDefault = 1024;
  localparam int SampleBitsDefault = 26;
  localparam int FractionBitsDefault = 8;

  localparam int QueueDepth = 2;
  localparam int MinItems = 2;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MULT = 6'b000010,
    ST_SUB  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_DONE = 6'b100000
  } back_state_t;

endpackage

[src/rwl_sample_if.sv]
`timescale 1ns / 1ps

interface rwl_sample_if;
  logic valid;
  logic ready;
  logic [rwl_pkg::SampleW-1:0] sample;
  logic last_item;

  modport source (output valid, output sample, output last_item, input ready);
  modport sink (input valid, input sample, input last_item, output ready);
endinterface

[src/rwl_result_if.sv]
`timescale 1ns / 1ps

interface rwl_result_if;
  logic valid;
  logic ready;
  logic [rwl_pkg::ScoreW-1:0] score;
  logic [rwl_pkg::ItemsW-1:0] items_seen;
  logic overflowed;

  modport source (output valid, output score, output items_seen, output overflowed,
                  input ready);
  modport sink (input valid, input score, input items_seen, input overflowed,
                output ready);
endinterface

[src/rwl_front.sv]
`timescale 1ns / 1ps

module rwl_front #(
  parameter int MAX_ITEMS = rwl_pkg::MaxItemsDefault,
  parameter int SAMPLE_BITS = rwl_pkg::SampleBitsDefault,
  parameter int DEPTH = rwl_pkg::QueueDepth,
  localparam int CountW = $clog2(MAX_ITEMS + 1),
  localparam int SumW = 2 * SAMPLE_BITS + $clog2(MAX_ITEMS),
  localparam int LevelW = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [rwl_pkg::SampleW-1:0] sample,
  input  logic last_item,
  input  logic [LevelW-1:0] q_level,
  output logic push,
  output logic [SumW-1:0] push_sum,
  output logic [SAMPLE_BITS-1:0] push_max,
  output logic [CountW-1:0] push_count,
  output logic push_ovf
);

  localparam logic [rwl_pkg::SampleW-1:0] SampleMax =
    rwl_pkg::SampleW'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [CountW-1:0] count;
  logic [SAMPLE_BITS-1:0] largest;
  logic ovf;
  logic [SumW-1:0] sum;

  logic p_valid;
  logic p_last;
  logic [2*SAMPLE_BITS-1:0] p_sq;
  logic [CountW-1:0] p_count;
  logic [SAMPLE_BITS-1:0] p_max;
  logic p_ovf;

  logic accept;
  logic take;
  logic [SAMPLE_BITS-1:0] s;
  logic [CountW-1:0] count_next;
  logic [SAMPLE_BITS-1:0] largest_next;
  logic ovf_next;
  logic [SumW-1:0] total;
  logic [LevelW+1:0] need;

  // A closing beat needs a queue slot, as does a summary still on its way in.
  assign need = (LevelW + 2)'(q_level) + (LevelW + 2)'(p_valid & p_last) + (LevelW + 2)'(1);
  assign in_ready = (need <= (LevelW + 2)'(DEPTH));
  assign accept = in_valid & in_ready;

  always_comb begin
    s = (sample > SampleMax) ? SAMPLE_BITS'(SampleMax) : SAMPLE_BITS'(sample);
    take = (count < CountW'(MAX_ITEMS));
    count_next = take ? count + CountW'(1) : count;
    largest_next = (take && (s > largest)) ? s : largest;
    ovf_next = ovf | ~take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      largest <= '0;
      ovf <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      p_valid <= accept;
      if (accept) begin
        if (last_item) begin
          count <= '0;
          largest <= '0;
          ovf <= 1'b0;
        end else begin
          count <= count_next;
          largest <= largest_next;
          ovf <= ovf_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_last <= last_item;
      p_sq <= take ? s * s : '0;
      p_count <= count_next;
      p_max <= largest_next;
      p_ovf <= ovf_next;
    end
  end

  assign total = sum + SumW'(p_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (p_valid) begin
      sum <= p_last ? '0 : total;
    end
  end

  assign push = p_valid & p_last;
  assign push_sum = total;
  assign push_max = p_max;
  assign push_count = p_count;
  assign push_ovf = p_ovf;

endmodule

[src/rwl_queue.sv]
`timescale 1ns / 1ps

module rwl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rwl_pkg::QueueDepth,
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LevelW = $clog2(DEPTH + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic pop,
  output logic [WIDTH-1:0] rd_data,
  output logic not_empty,
  output logic [LevelW-1:0] level
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic do_pop;

  assign not_empty = (level != '0);
  assign do_pop = pop & not_empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !do_pop) begin
        level <= level + LevelW'(1);
      end else if (!push && do_pop) begin
        level <= level - LevelW'(1);
      end
    end
  end

endmodule

[src/rwl_back.sv]
`timescale 1ns / 1ps

module rwl_back #(
  parameter int MAX_ITEMS = rwl_pkg::MaxItemsDefault,
  parameter int SAMPLE_BITS = rwl_pkg::SampleBitsDefault,
  parameter int FRACTION_BITS = rwl_pkg::FractionBitsDefault,
  localparam int CountW = $clog2(MAX_ITEMS + 1),
  localparam int SumW = 2 * SAMPLE_BITS + $clog2(MAX_ITEMS),
  localparam int XW = SumW + 2 * FRACTION_BITS,
  localparam int QE = XW + (XW % 2),
  localparam int RW = QE / 2,
  localparam int StepW = $clog2(QE + 1)
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  logic [SumW-1:0] q_sum,
  input  logic [SAMPLE_BITS-1:0] q_max,
  input  logic [CountW-1:0] q_count,
  input  logic q_ovf,
  output logic out_valid,
  input  logic out_ready,
  output logic [rwl_pkg::ScoreW-1:0] score,
  output logic [rwl_pkg::ItemsW-1:0] items_seen,
  output logic overflowed
);

  rwl_pkg::back_state_t state;

  logic [SumW-1:0] sum;
  logic [SAMPLE_BITS-1:0] largest;
  logic [CountW-1:0] n;
  logic ovf;
  logic [2*SAMPLE_BITS-1:0] mm;
  logic [QE-1:0] shreg;
  logic [CountW-1:0] drem;
  logic [RW+1:0] srem;
  logic [RW-1:0] root;
  logic [StepW-1:0] step;

  logic [CountW:0] dtrial;
  logic dge;
  logic [CountW:0] ddiff;
  logic [RW+3:0] scat;
  logic [RW+3:0] strial;
  logic sge;
  logic [RW+3:0] sdiff;
  logic [SumW-1:0] diff;
  logic out_free;

  assign q_pop = (state == rwl_pkg::ST_IDLE);
  assign out_free = ~out_valid | out_ready;

  always_comb begin
    dtrial = {drem, shreg[QE-1]};
    dge = (dtrial >= {1'b0, n});
    ddiff = dtrial - {1'b0, n};
    scat = {srem, shreg[QE-1 -: 2]};
    strial = {2'b00, root, 2'b01};
    sge = (scat >= strial);
    sdiff = scat - strial;
    diff = sum - SumW'(mm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rwl_pkg::ST_IDLE;
    end else begin
      case (state)
        rwl_pkg::ST_IDLE: begin
          if (q_valid) begin
            state <= rwl_pkg::ST_MULT;
          end
        end
        rwl_pkg::ST_MULT: state <= rwl_pkg::ST_SUB;
        rwl_pkg::ST_SUB: begin
          if (n < CountW'(rwl_pkg::MinItems)) begin
            state <= rwl_pkg::ST_DONE;
          end else begin
            state <= rwl_pkg::ST_DIV;
          end
        end
        rwl_pkg::ST_DIV: begin
          if (step == StepW'(QE - 1)) begin
            state <= rwl_pkg::ST_SQRT;
          end
        end
        rwl_pkg::ST_SQRT: begin
          if (step == StepW'(RW - 1)) begin
            state <= rwl_pkg::ST_DONE;
          end
        end
        rwl_pkg::ST_DONE: begin
          if (out_free) begin
            state <= rwl_pkg::ST_IDLE;
          end
        end
        default: state <= rwl_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      rwl_pkg::ST_IDLE: begin
        sum <= q_sum;
        largest <= q_max;
        n <= q_count;
        ovf <= q_ovf;
      end
      rwl_pkg::ST_MULT: begin
        mm <= largest * largest;
      end
      rwl_pkg::ST_SUB: begin
        shreg <= QE'(diff) << (2 * FRACTION_BITS);
        drem <= '0;
        root <= '0;
        step <= '0;
      end
      rwl_pkg::ST_DIV: begin
        drem <= dge ? CountW'(ddiff) : CountW'(dtrial);
        shreg <= {shreg[QE-2:0], dge};
        if (step == StepW'(QE - 1)) begin
          step <= '0;
          srem <= '0;
        end else begin
          step <= step + StepW'(1);
        end
      end
      rwl_pkg::ST_SQRT: begin
        srem <= sge ? (RW + 2)'(sdiff) : (RW + 2)'(scat);
        root <= {root[RW-2:0], sge};
        shreg <= {shreg[QE-3:0], 2'b00};
        step <= step + StepW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rwl_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rwl_pkg::ST_DONE && out_free) begin
      score <= rwl_pkg::ScoreW'(root);
      items_seen <= rwl_pkg::ItemsW'(n);
      overflowed <= ovf;
    end
  end

endmodule

[src/rms_without_largest_unit.sv]
`timescale 1ns / 1ps
// Input beats are taken one per cycle while the queue has a free slot for a closing beat.
// A list summary passes through the queue to the back end, which multiplies, subtracts, divides
// and takes the root in its one-bit-per-cycle divider and root unit (skipped for under two items).
// The back end takes a new list only when idle; the two-entry queue absorbs short lists meanwhile.
// Synchronous reset clears the running totals, the queue and the back-end state machine.

module rms_without_largest_unit #(
  parameter int MAX_ITEMS = rwl_pkg::MaxItemsDefault,
  parameter int SAMPLE_BITS = rwl_pkg::SampleBitsDefault,
  parameter int FRACTION_BITS = rwl_pkg::FractionBitsDefault
) (
  input logic clk,
  input logic rst,
  rwl_sample_if.sink samples,
  rwl_result_if.source results
);

  localparam int CountW = $clog2(MAX_ITEMS + 1);
  localparam int SumW = 2 * SAMPLE_BITS + $clog2(MAX_ITEMS);
  localparam int WordW = SumW + SAMPLE_BITS + CountW + 1;
  localparam int LevelW = $clog2(rwl_pkg::QueueDepth + 1);

  logic push;
  logic [SumW-1:0] push_sum;
  logic [SAMPLE_BITS-1:0] push_max;
  logic [CountW-1:0] push_count;
  logic push_ovf;
  logic [LevelW-1:0] q_level;
  logic q_valid;
  logic q_pop;
  logic [WordW-1:0] q_word;

  rwl_front #(
    .MAX_ITEMS(MAX_ITEMS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .DEPTH(rwl_pkg::QueueDepth)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(samples.valid),
    .in_ready(samples.ready),
    .sample(samples.sample),
    .last_item(samples.last_item),
    .q_level(q_level),
    .push(push),
    .push_sum(push_sum),
    .push_max(push_max),
    .push_count(push_count),
    .push_ovf(push_ovf)
  );

  rwl_queue #(
    .WIDTH(WordW),
    .DEPTH(rwl_pkg::QueueDepth)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .wr_data({push_sum, push_max, push_count, push_ovf}),
    .pop(q_pop),
    .rd_data(q_word),
    .not_empty(q_valid),
    .level(q_level)
  );

  rwl_back #(
    .MAX_ITEMS(MAX_ITEMS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_pop(q_pop),
    .q_sum(q_word[WordW-1 -: SumW]),
    .q_max(q_word[CountW+SAMPLE_BITS -: SAMPLE_BITS]),
    .q_count(q_word[CountW -: CountW]),
    .q_ovf(q_word[0]),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .score(results.score),
    .items_seen(results.items_seen),
    .overflowed(results.overflowed)
  );

endmodule
